/* rtl/rsum_pkg.sv */
// ----------------------------------------------------------------------------
// rsum_pkg
// Shared widths, codes and types of the range sum tree.
// ----------------------------------------------------------------------------
package rsum_pkg;

  localparam int unsigned POS_W  = 6;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SIZE_W = 7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UWALK,
    ST_QWALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] range_sum;
    logic                    bad_index;
  } res_t;

endpackage

/* rtl/rsum_if.sv */
// ----------------------------------------------------------------------------
// rsum_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface rsum_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic        [rsum_pkg::POS_W-1:0]  position;
  logic signed [rsum_pkg::VAL_W-1:0]  new_value;
  logic        [rsum_pkg::POS_W-1:0]  range_first;
  logic        [rsum_pkg::POS_W-1:0]  range_last;

  modport source (output valid, mode, position, new_value, range_first, range_last,
                  input ready);
  modport sink   (input valid, mode, position, new_value, range_first, range_last,
                  output ready);
endinterface

interface rsum_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rsum_pkg::VAL_W-1:0]  range_sum;
  logic                               bad_index;

  modport source (output valid, range_sum, bad_index, input ready);
  modport sink   (input valid, range_sum, bad_index, output ready);
endinterface

/* rtl/rsum_mem.sv */
// ----------------------------------------------------------------------------
// rsum_mem
// Partial sum store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rsum_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [rsum_pkg::VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_a_i,
  input  logic [AW-1:0]              raddr_b_i,
  output logic [rsum_pkg::VAL_W-1:0] rdata_a_o,
  output logic [rsum_pkg::VAL_W-1:0] rdata_b_o
);

  logic [rsum_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* rtl/rsum_engine.sv */
// ----------------------------------------------------------------------------
// rsum_engine
// Sequencer: clearing pass, leaf-to-root update walk, bottom-up range walk.
// ----------------------------------------------------------------------------
module rsum_engine #(
  parameter  int unsigned LEAVES = 64,
  localparam int unsigned NW     = $clog2(2 * LEAVES),
  localparam int unsigned CW     = (NW + 1 > rsum_pkg::SIZE_W) ? NW + 1 : rsum_pkg::SIZE_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rsum_in_if.sink                    in_i,
  input  logic [CW-1:0]              size_eff_i,
  input  logic                       slot_free_i,
  output logic                       res_valid_o,
  output rsum_pkg::res_t             res_o,
  output logic                       mem_we_o,
  output logic [NW-1:0]              mem_waddr_o,
  output logic [rsum_pkg::VAL_W-1:0] mem_wdata_o,
  output logic [NW-1:0]              mem_raddr_a_o,
  output logic [NW-1:0]              mem_raddr_b_o,
  input  logic [rsum_pkg::VAL_W-1:0] mem_rdata_a_i,
  input  logic [rsum_pkg::VAL_W-1:0] mem_rdata_b_i
);

  localparam int unsigned LAST = 2 * LEAVES - 1;
  localparam int unsigned VW   = rsum_pkg::VAL_W;

  rsum_pkg::state_e state_q, state_d;

  logic [NW-1:0] clr_q, clr_d;
  logic [NW-1:0] node_q, node_d;
  logic [VW-1:0] carry_q, carry_d;
  logic [NW:0]   lo_q, lo_d, hi_q, hi_d;
  logic          pa_q, pa_d, pb_q, pb_d;
  logic [VW-1:0] acc_q, acc_d;
  logic          bad_q, bad_d;

  logic          accept, is_update, upd_bad, q_empty, issue;
  logic [CW-1:0] pos_x, first_x, last_x, last_c;
  logic [NW-1:0] leaf, parent;
  logic [NW:0]   lo_init, hi_init, hi_m1;
  logic [VW-1:0] upd_sum;

  assign accept    = in_i.valid && in_i.ready;
  assign is_update = (in_i.mode == rsum_pkg::MODE_UPDATE);
  assign pos_x     = CW'(in_i.position);
  assign first_x   = CW'(in_i.range_first);
  assign last_x    = CW'(in_i.range_last);
  assign last_c    = (last_x > size_eff_i - CW'(1)) ? size_eff_i - CW'(1) : last_x;
  assign q_empty   = first_x > last_c;
  assign upd_bad   = pos_x >= size_eff_i;
  assign leaf      = NW'(pos_x + CW'(LEAVES));
  assign lo_init   = (NW+1)'(first_x + CW'(LEAVES));
  assign hi_init   = (NW+1)'(last_c + CW'(LEAVES) + CW'(1));
  assign parent    = node_q >> 1;
  assign upd_sum   = carry_q + mem_rdata_a_i;
  assign issue     = lo_q < hi_q;
  assign hi_m1     = hi_q - (NW+1)'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsum_pkg::ST_CLEAR: begin
        if (clr_q == NW'(LAST)) state_d = rsum_pkg::ST_IDLE;
      end
      rsum_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_update)   state_d = rsum_pkg::ST_QWALK;
          else if (upd_bad) state_d = rsum_pkg::ST_FINISH;
          else              state_d = rsum_pkg::ST_UWALK;
        end
      end
      rsum_pkg::ST_UWALK: begin
        if (parent == NW'(1)) state_d = rsum_pkg::ST_FINISH;
      end
      rsum_pkg::ST_QWALK: begin
        if (!issue) state_d = rsum_pkg::ST_FINISH;
      end
      rsum_pkg::ST_FINISH: begin
        if (slot_free_i) state_d = rsum_pkg::ST_IDLE;
      end
      default: state_d = rsum_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_d         = clr_q;
    node_d        = node_q;
    carry_d       = carry_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    pa_d          = 1'b0;
    pb_d          = 1'b0;
    acc_d         = acc_q;
    bad_d         = bad_q;
    in_i.ready    = 1'b0;
    res_valid_o   = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = clr_q;
    mem_wdata_o   = '0;
    mem_raddr_a_o = lo_q[NW-1:0];
    mem_raddr_b_o = hi_m1[NW-1:0];
    unique case (state_q)
      rsum_pkg::ST_CLEAR: begin
        mem_we_o = 1'b1;
        clr_d    = clr_q + NW'(1);
      end
      rsum_pkg::ST_IDLE: begin
        in_i.ready    = 1'b1;
        mem_raddr_a_o = leaf ^ NW'(1);
        if (accept) begin
          acc_d   = '0;
          bad_d   = is_update && upd_bad;
          node_d  = leaf;
          carry_d = in_i.new_value;
          if (q_empty) begin
            lo_d = '0;
            hi_d = '0;
          end else begin
            lo_d = lo_init;
            hi_d = hi_init;
          end
          if (is_update && !upd_bad) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = leaf;
            mem_wdata_o = in_i.new_value;
          end
        end
      end
      rsum_pkg::ST_UWALK: begin
        mem_we_o      = 1'b1;
        mem_waddr_o   = parent;
        mem_wdata_o   = upd_sum;
        mem_raddr_a_o = parent ^ NW'(1);
        carry_d       = upd_sum;
        node_d        = parent;
      end
      rsum_pkg::ST_QWALK: begin
        acc_d = acc_q + (pa_q ? mem_rdata_a_i : '0) + (pb_q ? mem_rdata_b_i : '0);
        if (issue) begin
          pa_d = lo_q[0];
          pb_d = hi_q[0];
          lo_d = (lo_q + (NW+1)'(lo_q[0])) >> 1;
          hi_d = (hi_q - (NW+1)'(hi_q[0])) >> 1;
        end
      end
      rsum_pkg::ST_FINISH: begin
        res_valid_o = slot_free_i;
      end
      default: ;
    endcase
  end

  assign res_o.range_sum = acc_q;
  assign res_o.bad_index = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsum_pkg::ST_CLEAR;
      clr_q   <= '0;
      pa_q    <= 1'b0;
      pb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    carry_q <= carry_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    acc_q   <= acc_d;
    bad_q   <= bad_d;
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> slot_free_i)
    else $error("result issued while output slot busy");

  a_bad_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_update && upd_bad) |-> !mem_we_o ##1 !mem_we_o)
    else $error("rejected update touched the tree");

  a_no_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && state_q != rsum_pkg::ST_CLEAR) |-> (mem_waddr_o != '0))
    else $error("write to unused node zero");

  a_pending_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pa_q || pb_q) |-> (state_q == rsum_pkg::ST_QWALK))
    else $error("pending read outside range walk");

endmodule

/* rtl/range_sum_point_update_tree.sv */
// ----------------------------------------------------------------------------
// range_sum_point_update_tree
// Segment tree of wrapped 32-bit partial sums with point update and range sum.
//
// Requests enter on in_i (valid/ready); mode selects update or query.
// One result item per request leaves on out_o (valid/ready).
// size_in_use is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while the block idles, which the block does not enforce. 0 acts as 1 and values
// above LEAVES act as LEAVES. Update: leaf write at accept, then a walk that
//   writes each parent up to the root, then the result state.
// Query: a bottom-up range walk over the tree levels, a final step to fold the
//   last reads, then the result state.
// in_i.ready is high only in the idle state, entered as the result is registered:
//   a new request is taken only once the result of the last one is registered.
// An update at or beyond the size in use leaves the tree alone and returns
// bad_index = 1. One write and two read ports of the store; one request at a time.
// After reset the store is zeroed node by node, with in_i.ready low.
// A result held under a stalled receiver does not block the next request;
// that request finishes its walk and then waits for the output register.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree #(
  parameter int unsigned LEAVES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rsum_pkg::SIZE_W-1:0] cfg_wdata_i,
  rsum_in_if.sink                     in_i,
  rsum_out_if.source                  out_o
);

  localparam int unsigned NW = $clog2(2 * LEAVES);
  localparam int unsigned CW = (NW + 1 > rsum_pkg::SIZE_W) ? NW + 1 : rsum_pkg::SIZE_W;
  localparam int unsigned VW = rsum_pkg::VAL_W;

  logic [rsum_pkg::SIZE_W-1:0] size_q;
  logic [CW-1:0]               size_x, size_eff;

  logic           out_valid_q;
  rsum_pkg::res_t out_res_q;
  logic           slot_free, res_valid;
  rsum_pkg::res_t res;

  logic          mem_we;
  logic [NW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [VW-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= rsum_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  assign size_x = CW'(size_q);

  always_comb begin
    if (size_q == '0)                size_eff = CW'(1);
    else if (size_x > CW'(LEAVES))   size_eff = CW'(LEAVES);
    else                             size_eff = size_x;
  end

  assign slot_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.range_sum = out_res_q.range_sum;
  assign out_o.bad_index = out_res_q.bad_index;

  rsum_engine #(
    .LEAVES (LEAVES)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .size_eff_i    (size_eff),
    .slot_free_i   (slot_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  rsum_mem #(
    .DEPTH (2 * LEAVES),
    .AW    (NW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

/* tb/rsum_result_checker.sv */
// ----------------------------------------------------------------------------
// rsum_result_checker
// Watches the request and result channels of the range sum tree, keeps its
// own copy of the element array and size register, works out the result of
// every accepted request and compares each result item, field by field,
// with the oldest one still due. Mismatches are counted for the top level.
// ----------------------------------------------------------------------------
module rsum_result_checker #(
  parameter int unsigned LEAVES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rsum_pkg::SIZE_W-1:0] cfg_wdata_i,
  rsum_in_if                          req_ch,
  rsum_out_if                         res_ch,
  output int                          outstanding_o,
  output int                          mismatches_o
);

  localparam int unsigned VW = rsum_pkg::VAL_W;

  logic [rsum_pkg::VAL_W-1:0]  elements [LEAVES];
  logic [rsum_pkg::SIZE_W-1:0] size_reg;
  rsum_pkg::res_t              sums_due [$];

  // 0 acts as 1, anything above LEAVES acts as LEAVES
  function automatic int unsigned reach();
    if (size_reg == '0) begin
      return 1;
    end
    if (32'(size_reg) > LEAVES) begin
      return LEAVES;
    end
    return 32'(size_reg);
  endfunction

  function automatic rsum_pkg::res_t resolve_request(logic mode,
                                                     logic [rsum_pkg::POS_W-1:0] pos,
                                                     logic [rsum_pkg::VAL_W-1:0] val,
                                                     logic [rsum_pkg::POS_W-1:0] first,
                                                     logic [rsum_pkg::POS_W-1:0] last);
    rsum_pkg::res_t             r;
    int unsigned                span;
    int unsigned                hi;
    int unsigned                i;
    logic [rsum_pkg::VAL_W-1:0] acc;
    span        = reach();
    r.range_sum = '0;
    r.bad_index = 1'b0;
    acc         = '0;
    if (mode == rsum_pkg::MODE_UPDATE) begin
      if (32'(pos) < span) begin
        elements[pos] = val;
      end else begin
        r.bad_index = 1'b1;
      end
    end else begin
      hi = (32'(last) > span - 1) ? span - 1 : 32'(last);
      for (i = 32'(first); i <= hi; i++) begin
        acc += elements[i];
      end
      r.range_sum = acc;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [rsum_pkg::VAL_W-1:0] got,
                               logic [rsum_pkg::VAL_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    rsum_pkg::res_t seen;
    rsum_pkg::res_t due;
    if (!rst_ni) begin
      foreach (elements[k]) begin
        elements[k] = '0;
      end
      size_reg = rsum_pkg::SIZE_RESET;
      sums_due.delete();
      outstanding_o = 0;
      mismatches_o  = 0;
    end else begin
      // results leave before a request accepted on the same edge can finish
      if (res_ch.valid && res_ch.ready) begin
        seen.range_sum = res_ch.range_sum;
        seen.bad_index = res_ch.bad_index;
        if (sums_due.size() == 0) begin
          flag_mismatch("result item with none due", seen.range_sum, '0);
        end else begin
          due = sums_due.pop_front();
          if (seen.range_sum !== due.range_sum) begin
            flag_mismatch("range_sum", seen.range_sum, due.range_sum);
          end
          if (seen.bad_index !== due.bad_index) begin
            flag_mismatch("bad_index", VW'(seen.bad_index), VW'(due.bad_index));
          end
        end
      end
      // a request on the edge of a size write still sees the old size
      if (req_ch.valid && req_ch.ready) begin
        sums_due.push_back(resolve_request(req_ch.mode, req_ch.position,
                                           req_ch.new_value, req_ch.range_first,
                                           req_ch.range_last));
      end
      if (cfg_we_i) begin
        size_reg = cfg_wdata_i;
      end
      outstanding_o = sums_due.size();
    end
  end

endmodule

/* tb/tb_range_sum_point_update_tree.sv */
// ----------------------------------------------------------------------------
// tb_range_sum_point_update_tree
// Drives updates and range queries into the range sum tree under random
// gaps and receiver stalls, steps the size register through its extremes
// between phases, and gives the verdict from the checker's mismatch count and a stall watchdog.
// ----------------------------------------------------------------------------
module tb_range_sum_point_update_tree;

  localparam int unsigned LEAVES        = 64;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 120;
  localparam int unsigned POS_W         = rsum_pkg::POS_W;
  localparam int unsigned VAL_W         = rsum_pkg::VAL_W;
  localparam int unsigned SIZE_W        = rsum_pkg::SIZE_W;

  typedef struct packed {
    logic             mode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;
    logic [POS_W-1:0] range_first;
    logic [POS_W-1:0] range_last;
  } request_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_wdata_i;
  int                outstanding;
  int                mismatches;
  int unsigned       quiet_cycles;
  int unsigned       hold_left;
  int unsigned       span;

  rsum_in_if  req_ch ();
  rsum_out_if res_ch ();

  range_sum_point_update_tree #(
    .LEAVES (LEAVES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_ch),
    .out_o       (res_ch)
  );

  rsum_result_checker #(
    .LEAVES (LEAVES)
  ) sum_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_ch        (req_ch),
    .res_ch        (res_ch),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned ready_hold(logic level);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (level) begin
      return (r < 80) ? $urandom_range(1, 6) : $urandom_range(30, 120);
    end
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    return (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60);
  endfunction

  function automatic int unsigned span_of(logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (32'(v) > LEAVES) ? LEAVES : 32'(v);
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0: begin
        return 32'h7fff_ffff;
      end
      1: begin
        return 32'h8000_0000;
      end
      2: begin
        return 32'hffff_ffff;
      end
      3: begin
        return '0;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic request_t update_req(int unsigned pos, logic [VAL_W-1:0] val);
    request_t r;
    r             = '0;
    r.mode        = rsum_pkg::MODE_UPDATE;
    r.position    = POS_W'(pos);
    r.new_value   = val;
    r.range_first = POS_W'($urandom);
    r.range_last  = POS_W'($urandom);
    return r;
  endfunction

  function automatic request_t query_req(int unsigned first, int unsigned last);
    request_t r;
    r             = '0;
    r.mode        = rsum_pkg::MODE_QUERY;
    r.position    = POS_W'($urandom);
    r.new_value   = $urandom;
    r.range_first = POS_W'(first);
    r.range_last  = POS_W'(last);
    return r;
  endfunction

  function automatic request_t random_req();
    request_t    r;
    int unsigned a;
    r.mode      = $urandom_range(0, 1) ? rsum_pkg::MODE_QUERY : rsum_pkg::MODE_UPDATE;
    r.position  = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, span - 1))
                                             : POS_W'($urandom_range(0, LEAVES - 1));
    r.new_value = random_value();
    if ($urandom_range(0, 9) < 6) begin
      a             = $urandom_range(0, span - 1);
      r.range_first = POS_W'(a);
      r.range_last  = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(a, LEAVES - 1))
                                                  : POS_W'($urandom_range(a, span - 1));
    end else begin
      r.range_first = POS_W'($urandom_range(0, LEAVES - 1));
      r.range_last  = POS_W'($urandom_range(0, LEAVES - 1));
    end
    return r;
  endfunction

  task automatic send_request(request_t r, logic steady);
    int unsigned gap;
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= r.mode;
    req_ch.position    <= r.position;
    req_ch.new_value   <= r.new_value;
    req_ch.range_first <= r.range_first;
    req_ch.range_last  <= r.range_last;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    span         = span_of(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // receiver: alternating ready stretches of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left == 0) begin
      res_ch.ready <= ~res_ch.ready;
      hold_left    <= ready_hold(~res_ch.ready);
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] phase_sizes [PHASES];
    logic [SIZE_W-1:0] v;
    logic              steady;
    int unsigned       p;
    int unsigned       n;
    phase_sizes = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd63, 7'd65,
                    7'd0, 7'd64, 7'd0, 7'd32, 7'd0, 7'd64};
    span                = LEAVES;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= rsum_pkg::MODE_UPDATE;
    req_ch.position    <= '0;
    req_ch.new_value   <= '0;
    req_ch.range_first <= '0;
    req_ch.range_last  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full size after reset: zeroed store, wrap-around, reversed range
    send_request(query_req(0, 63), 1'b0);
    send_request(update_req(0, 32'h7fff_ffff), 1'b0);
    send_request(update_req(63, 32'h8000_0000), 1'b0);
    send_request(update_req(1, 32'h0000_0001), 1'b0);
    send_request(query_req(0, 1), 1'b0);
    send_request(query_req(0, 63), 1'b0);
    send_request(query_req(63, 63), 1'b0);
    send_request(query_req(5, 3), 1'b0);
    send_request(update_req(62, 32'hffff_ffff), 1'b0);
    send_request(query_req(62, 63), 1'b0);
    send_request(update_req(63, '0), 1'b0);
    // reduced size: rejected updates, clipped and empty queries
    write_size(7'd10);
    send_request(update_req(10, 32'h1234_5678), 1'b0);
    send_request(update_req(63, 32'hdead_beef), 1'b0);
    send_request(update_req(9, 32'h1234_5678), 1'b0);
    send_request(query_req(0, 63), 1'b0);
    send_request(query_req(12, 20), 1'b0);
    send_request(query_req(9, 9), 1'b0);
    // zero size acts as one element
    write_size(7'd0);
    send_request(update_req(0, 32'hffff_fffb), 1'b0);
    send_request(update_req(1, 32'h0000_0055), 1'b0);
    send_request(query_req(0, 63), 1'b0);
    send_request(query_req(1, 1), 1'b0);
    // oversize clamps to the full tree; hidden elements reappear
    write_size(7'd127);
    send_request(query_req(0, 63), 1'b0);
    send_request(update_req(63, 32'h0000_002a), 1'b0);
    write_size(7'd65);
    send_request(query_req(62, 63), 1'b0);

    for (p = 0; p < PHASES; p++) begin
      v = (p == 8 || p == 10) ? 7'($urandom_range(0, 127)) : phase_sizes[p];
      write_size(v);
      steady = (p % 4 == 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_req(), steady);
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
